// File: rtl/stlb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stlb_pkg
// Types, constants and field codes that the session table files share.
// ---------------------------------------------------------------------------
package stlb_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam logic [31:0] DEFAULT_LIFETIME_S = 32'd7776000;
    localparam logic [16:0] DEFAULT_CAP_S = 17'd300;
    localparam logic [4:0] MAX_SHIFT = 5'd16;
    localparam logic [25:0] RETRY_MAX_MS = 26'd65536000;
    localparam logic [31:0] ALERT_COUNT = 32'd5;
    // remaining lockout in us at which the wait in ms saturates
    localparam logic [63:0] LOCK_SAT_US = 64'd65536000000;
    // floor(2^33 / 125): (x >> 4) * this >> 32 is within 2 of x / 1000
    localparam logic [26:0] RECIP_2_125 = 27'd68719476;

    // request kinds
    localparam logic [1:0] KIND_LOGIN = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_LOGOUT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DISABLED = 3'd1;
    localparam logic [2:0] ST_LOCKED = 3'd2;
    localparam logic [2:0] ST_BAD_PW = 3'd3;
    localparam logic [2:0] ST_NO_SESSION = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LOGIN_ENABLED = 2'd0;
    localparam logic [1:0] CFG_LIFETIME = 2'd1;
    localparam logic [1:0] CFG_CAP = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] hash_word0;
        logic [63:0] hash_word1;
        logic [63:0] hash_word2;
        logic [63:0] hash_word3;
        logic        password_matches;
        logic [62:0] monotonic_us;
        logic [62:0] wall_time_s;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [25:0] backoff_ms;
        logic [2:0]  slot_index;
        logic        alert_repeat_failures;
        logic        table_changed;
    } t_rsp;

endpackage
`default_nettype wire

// File: rtl/session_table_with_login_backoff.sv
`default_nettype none
// ---------------------------------------------------------------------------
// session_table_with_login_backoff
// Session token table in one RAM, slot flags and lockout state in registers.
// ---------------------------------------------------------------------------
// Lookup and logout read, then check, each slot in turn; a lookup hit stops early.
// A successful login scans the same way, then writes. A locked-out login goes
// through S_MUL and S_FIX (skipped when the wait saturates); other logins answer
// after S_RD. One transaction in flight, the next accepted in the cycle after the
// result leaves. Reset clears slot flags, failure count and lockout, clears the
// login enable, sets lifetime and cap to defaults; unflagged slots read as empty.
module session_table_with_login_backoff #(
    parameter int SESSION_SLOTS = stlb_pkg::SLOTS_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  stlb_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output stlb_pkg::t_rsp      o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [31:0]         i_cfg_data
);
    localparam int SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int CW = $clog2(SESSION_SLOTS + 1);
    localparam int EW = 256 + 63;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_WR    = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_FIX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    stlb_pkg::t_req r_req;
    stlb_pkg::t_rsp r_rsp, n_rsp;
    logic [CW-1:0] r_idx, n_idx;
    logic [SESSION_SLOTS-1:0] r_used, n_used;
    logic [31:0] r_fail, n_fail;
    logic [63:0] r_lock, n_lock;
    logic r_en;
    logic [31:0] r_life;
    logic [16:0] r_cap;
    logic r_found, n_found;
    logic [SW-1:0] r_best, n_best;
    logic [62:0] r_best_t, n_best_t;
    logic r_have_free, n_have_free;
    logic [58:0] r_prod, n_prod;

    logic ram_we;
    logic [SW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    stlb_ram #(.WIDTH(EW), .DEPTH(1 << SW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // entry fields from the ram
    logic [255:0] ent_hash, req_hash;
    logic [62:0]  ent_t;
    logic [SW-1:0] cur;
    logic hit;
    logic [63:0] life;
    logic [63:0] age;
    assign ent_hash = ram_rdata[EW-1:63];
    assign ent_t = ram_rdata[62:0];
    assign req_hash = {r_req.hash_word3, r_req.hash_word2,
                       r_req.hash_word1, r_req.hash_word0};
    assign cur = r_idx[SW-1:0];
    assign hit = r_used[cur] && (ent_hash == req_hash);
    assign life = {32'd0, (r_life == 32'd0) ? stlb_pkg::DEFAULT_LIFETIME_S : r_life};
    assign age = {1'b0, r_req.wall_time_s} - {1'b0, ent_t};

    // login failure math
    logic [31:0] fail_inc;
    logic [4:0]  shamt;
    logic [16:0] cap, delay;
    logic [17:0] pow;
    logic        locked;
    logic [63:0] rem_us;
    logic [25:0] q_est;
    logic [35:0] q_rem;
    assign fail_inc = (r_fail == 32'hFFFF_FFFF) ? r_fail : r_fail + 32'd1;
    assign shamt = ((fail_inc - 32'd1) > 32'd16) ? stlb_pkg::MAX_SHIFT
                                                : 5'(fail_inc - 32'd1);
    assign cap = (r_cap == 17'd0) ? stlb_pkg::DEFAULT_CAP_S : r_cap;
    assign pow = 18'd1 << shamt;
    assign delay = ({1'b0, cap} < pow) ? cap : pow[16:0];
    assign locked = ({1'b0, r_req.monotonic_us} < r_lock);
    assign rem_us = r_lock - {1'b0, r_req.monotonic_us};

    // remaining ms: reciprocal estimate, then up to two ms of correction
    assign q_est = r_prod[57:32];
    assign q_rem = rem_us[35:0] - 36'(q_est) * 36'd1000;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data = r_rsp;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_rsp = r_rsp;
        n_idx = r_idx;
        n_used = r_used;
        n_fail = r_fail;
        n_lock = r_lock;
        n_found = r_found;
        n_best = r_best;
        n_best_t = r_best_t;
        n_have_free = r_have_free;
        n_prod = r_prod;
        ram_we = 1'b0;
        ram_addr = cur;
        ram_wdata = {req_hash, r_req.wall_time_s};
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_found = 1'b0;
                n_have_free = 1'b0;
                n_best = '0;
                n_best_t = '0;
                n_rsp = '{status: stlb_pkg::ST_NO_SESSION, backoff_ms: '0,
                          slot_index: '0, alert_repeat_failures: 1'b0,
                          table_changed: 1'b0};
                ram_addr = '0;
                if (i_in_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
                if (r_req.kind == stlb_pkg::KIND_LOGIN) begin
                    if (!r_en) begin
                        n_rsp.status = stlb_pkg::ST_DISABLED;
                        n_state = S_OUT;
                    end else if (locked) begin
                        n_rsp.status = stlb_pkg::ST_LOCKED;
                        if (rem_us >= stlb_pkg::LOCK_SAT_US) begin
                            n_rsp.backoff_ms = stlb_pkg::RETRY_MAX_MS;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_MUL;
                        end
                    end else if (!r_req.password_matches) begin
                        n_fail = fail_inc;
                        n_lock = {1'b0, r_req.monotonic_us} + 64'(delay) * 64'd1000000;
                        n_rsp.backoff_ms = 26'(delay) * 26'd1000;
                        n_rsp.alert_repeat_failures = (fail_inc == stlb_pkg::ALERT_COUNT);
                        n_rsp.status = stlb_pkg::ST_BAD_PW;
                        n_state = S_OUT;
                    end
                end else if (r_req.kind == stlb_pkg::KIND_LOGOUT) begin
                    n_rsp.status = stlb_pkg::ST_OK;
                end else if (r_req.kind != stlb_pkg::KIND_LOOKUP) begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                n_prod = {27'd0, rem_us[35:4]} * {32'd0, stlb_pkg::RECIP_2_125};
                n_state = S_FIX;
            end
            S_FIX: begin
                n_rsp.backoff_ms = q_est + ((q_rem >= 36'd2000) ? 26'd2 :
                                            (q_rem >= 36'd1000) ? 26'd1 : 26'd0);
                n_state = S_OUT;
            end
            S_CHK: begin
                // ram data for slot cur is valid here
                n_state = S_RD;
                n_idx = r_idx + CW'(1);
                ram_addr = SW'(r_idx + CW'(1));
                if (r_req.kind == stlb_pkg::KIND_LOGIN) begin
                    if (!r_have_free) begin
                        if (!r_used[cur]) begin
                            n_have_free = 1'b1;
                            n_best = cur;
                        end else if (r_idx == '0 || ent_t < r_best_t) begin
                            n_best = cur;
                            n_best_t = ent_t;
                        end
                    end
                    if (r_idx == CW'(SESSION_SLOTS - 1)) begin
                        n_state = S_WR;
                    end
                end else if (r_req.kind == stlb_pkg::KIND_LOOKUP) begin
                    if (hit) begin
                        n_rsp.slot_index = 3'(cur);
                        n_rsp.status = stlb_pkg::ST_OK;
                        ram_addr = cur;
                        if (r_req.wall_time_s != '0 && ent_t == '0) begin
                            ram_we = 1'b1;
                            n_rsp.table_changed = 1'b1;
                        end
                        if (r_req.wall_time_s != '0 && ent_t != '0 &&
                            r_req.wall_time_s > ent_t && age > life) begin
                            ram_we = 1'b0;
                            n_used[cur] = 1'b0;
                            n_rsp.table_changed = 1'b1;
                            n_rsp.status = stlb_pkg::ST_NO_SESSION;
                        end
                        ram_wdata = {ent_hash, r_req.wall_time_s};
                        n_state = S_OUT;
                    end else if (r_idx == CW'(SESSION_SLOTS - 1)) begin
                        n_state = S_OUT;
                    end
                end else begin
                    if (hit) begin
                        n_used[cur] = 1'b0;
                        n_rsp.table_changed = 1'b1;
                        if (!r_found) begin
                            n_rsp.slot_index = 3'(cur);
                        end
                        n_found = 1'b1;
                    end
                    if (r_idx == CW'(SESSION_SLOTS - 1)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_WR: begin
                ram_we = 1'b1;
                ram_addr = r_best;
                n_used[r_best] = 1'b1;
                n_fail = '0;
                n_lock = '0;
                n_rsp.status = stlb_pkg::ST_OK;
                n_rsp.slot_index = 3'(r_best);
                n_rsp.table_changed = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_fail <= '0;
            r_lock <= '0;
            r_en <= 1'b0;
            r_life <= stlb_pkg::DEFAULT_LIFETIME_S;
            r_cap <= stlb_pkg::DEFAULT_CAP_S;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_fail <= n_fail;
            r_lock <= n_lock;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    stlb_pkg::CFG_LOGIN_ENABLED: r_en <= i_cfg_data[0];
                    stlb_pkg::CFG_LIFETIME:      r_life <= i_cfg_data;
                    stlb_pkg::CFG_CAP:           r_cap <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        r_rsp <= n_rsp;
        r_idx <= n_idx;
        r_found <= n_found;
        r_best <= n_best;
        r_best_t <= n_best_t;
        r_have_free <= n_have_free;
        r_prod <= n_prod;
    end

    // checks
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("accept while result pending");
    a_ok_login_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> (r_fail == '0 && r_lock == '0))
        else $error("success did not clear lockout");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE)) else $error("config while busy");
endmodule
`default_nettype wire

// File: rtl/stlb_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stlb_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module stlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: dv/session_table_with_login_backoff_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// session_table_with_login_backoff_tb
// Drives logins, lookups and logouts into the session table. A predictor
// tracks the slots, the failure counter and the lockout deadline. A
// scoreboard class holds the expected responses and checks each accepted
// response field by field. Both sides idle at random.
// ---------------------------------------------------------------------------
module session_table_with_login_backoff_tb;

    localparam int NSLOT = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    // kind code with no defined operation
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // scoreboard of expected responses
    class rsp_scoreboard;
        stlb_pkg::t_rsp pending[$];
        int errors;

        function void note_request(stlb_pkg::t_rsp exp_rsp);
            pending.push_back(exp_rsp);
        endfunction

        function void check_response(stlb_pkg::t_rsp act);
            stlb_pkg::t_rsp exp_rsp;
            if (pending.size() == 0) begin
                $display("%0t: response with nothing expected, actual %h", $realtime, act);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (act.status !== exp_rsp.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $realtime, exp_rsp.status, act.status);
                errors++;
            end
            if (act.backoff_ms !== exp_rsp.backoff_ms) begin
                $display("%0t: backoff_ms expected %0d actual %0d",
                         $realtime, exp_rsp.backoff_ms, act.backoff_ms);
                errors++;
            end
            if (act.slot_index !== exp_rsp.slot_index) begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $realtime, exp_rsp.slot_index, act.slot_index);
                errors++;
            end
            if (act.alert_repeat_failures !== exp_rsp.alert_repeat_failures) begin
                $display("%0t: alert expected %0d actual %0d", $realtime,
                         exp_rsp.alert_repeat_failures, act.alert_repeat_failures);
                errors++;
            end
            if (act.table_changed !== exp_rsp.table_changed) begin
                $display("%0t: table_changed expected %0d actual %0d",
                         $realtime, exp_rsp.table_changed, act.table_changed);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    stlb_pkg::t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    stlb_pkg::t_rsp o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    session_table_with_login_backoff i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    rsp_scoreboard sb = new();

    // predictor state
    logic         pm_enabled = 1'b0;
    logic [31:0]  pm_lifetime = stlb_pkg::DEFAULT_LIFETIME_S;
    logic [16:0]  pm_cap = stlb_pkg::DEFAULT_CAP_S;
    logic [255:0] pm_hash [NSLOT];
    logic [62:0]  pm_created [NSLOT];
    logic         pm_used [NSLOT];
    logic [31:0]  pm_fail = '0;
    logic [63:0]  pm_locked_until = '0;

    // token pool so lookups and logouts hit stored sessions
    logic [255:0] token_pool [8];
    logic [62:0]  mono_now = '0;
    logic [62:0]  wall_now = 63'd1000;
    int           idle_cycles = 0;
    bit           timed_out = 0;

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            pm_hash[i] = '0;
            pm_created[i] = '0;
            pm_used[i] = 1'b0;
        end
    end

    function automatic stlb_pkg::t_rsp predict_session(stlb_pkg::t_req rq);
        stlb_pkg::t_rsp r;
        logic [255:0] h;
        logic [63:0] ms, delay, cap, life;
        logic [31:0] shift_amt;
        int slot;
        bit found;
        r = '0;
        r.status = stlb_pkg::ST_NO_SESSION;
        h = {rq.hash_word3, rq.hash_word2, rq.hash_word1, rq.hash_word0};
        if (rq.kind == stlb_pkg::KIND_LOGIN) begin
            if (!pm_enabled) begin
                r.status = stlb_pkg::ST_DISABLED;
            end else if ({1'b0, rq.monotonic_us} < pm_locked_until) begin
                ms = (pm_locked_until - {1'b0, rq.monotonic_us}) / 64'd1000;
                r.status = stlb_pkg::ST_LOCKED;
                r.backoff_ms = (ms > 64'(stlb_pkg::RETRY_MAX_MS)) ? stlb_pkg::RETRY_MAX_MS
                                                                   : ms[25:0];
            end else if (!rq.password_matches) begin
                if (pm_fail != 32'hFFFF_FFFF) pm_fail++;
                shift_amt = ((pm_fail - 32'd1) > 32'(stlb_pkg::MAX_SHIFT))
                          ? 32'(stlb_pkg::MAX_SHIFT) : pm_fail - 32'd1;
                delay = 64'd1 << shift_amt;
                cap = {47'd0, (pm_cap == 17'd0) ? stlb_pkg::DEFAULT_CAP_S : pm_cap};
                if (delay > cap) delay = cap;
                pm_locked_until = {1'b0, rq.monotonic_us} + delay * 64'd1000000;
                r.backoff_ms = 26'(delay * 64'd1000);
                r.alert_repeat_failures = (pm_fail == stlb_pkg::ALERT_COUNT);
                r.status = stlb_pkg::ST_BAD_PW;
            end else begin
                slot = -1;
                pm_fail = '0;
                pm_locked_until = '0;
                for (int i = 0; i < NSLOT; i++)
                    if (slot < 0 && !pm_used[i]) slot = i;
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < NSLOT; i++)
                        if (pm_created[i] < pm_created[slot]) slot = i;
                end
                pm_hash[slot] = h;
                pm_created[slot] = rq.wall_time_s;
                pm_used[slot] = 1'b1;
                r.status = stlb_pkg::ST_OK;
                r.slot_index = 3'(slot);
                r.table_changed = 1'b1;
            end
        end else if (rq.kind == stlb_pkg::KIND_LOOKUP) begin
            found = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!found && pm_used[i] && pm_hash[i] == h) begin
                    found = 1;
                    r.slot_index = 3'(i);
                    if (rq.wall_time_s != '0 && pm_created[i] == '0) begin
                        pm_created[i] = rq.wall_time_s;
                        r.table_changed = 1'b1;
                    end
                    life = {32'd0, (pm_lifetime == 32'd0) ? stlb_pkg::DEFAULT_LIFETIME_S
                                                          : pm_lifetime};
                    if (rq.wall_time_s != '0 && rq.wall_time_s > pm_created[i] &&
                        {1'b0, rq.wall_time_s - pm_created[i]} > life) begin
                        pm_hash[i] = '0;
                        pm_created[i] = '0;
                        pm_used[i] = 1'b0;
                        r.table_changed = 1'b1;
                        r.status = stlb_pkg::ST_NO_SESSION;
                    end else begin
                        r.status = stlb_pkg::ST_OK;
                    end
                end
            end
        end else if (rq.kind == stlb_pkg::KIND_LOGOUT) begin
            found = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (pm_used[i] && pm_hash[i] == h) begin
                    if (!found) r.slot_index = 3'(i);
                    found = 1;
                    pm_hash[i] = '0;
                    pm_created[i] = '0;
                    pm_used[i] = 1'b0;
                    r.table_changed = 1'b1;
                end
            end
            r.status = stlb_pkg::ST_OK;
        end
        return r;
    endfunction

    // receiver stall pattern and response check
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_data);
        if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 3));
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays up after the accept; the caller drops it before any idle time
    task automatic send_request(stlb_pkg::t_req rq);
        i_cfg_valid <= 1'b0;
        i_in_data <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(predict_session(rq));
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == stlb_pkg::CFG_LOGIN_ENABLED) pm_enabled = val[0];
        else if (idx == stlb_pkg::CFG_LIFETIME) pm_lifetime = val;
        else if (idx == stlb_pkg::CFG_CAP) pm_cap = val[16:0];
    endtask

    task automatic drain_responses();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 6) @(posedge i_clk);
    endtask

    function automatic stlb_pkg::t_req make_request(logic [1:0] kind, logic [255:0] h,
                                                    logic pw, logic [62:0] mono,
                                                    logic [62:0] wall);
        stlb_pkg::t_req rq;
        rq.kind = kind;
        {rq.hash_word3, rq.hash_word2, rq.hash_word1, rq.hash_word0} = h;
        rq.password_matches = pw;
        rq.monotonic_us = mono;
        rq.wall_time_s = wall;
        return rq;
    endfunction

    function automatic logic [255:0] rand_hash();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
    endfunction

    function automatic logic [62:0] rand_wide();
        return 63'({$urandom, $urandom});
    endfunction

    // random item weighted toward well-formed traffic
    task automatic send_random();
        stlb_pkg::t_req rq;
        logic [255:0] h;
        int sel;
        sel = $urandom_range(0, 99);
        h = ($urandom_range(0, 4) != 0) ? token_pool[$urandom_range(0, 7)] : rand_hash();
        if ($urandom_range(0, 3) == 0) mono_now = mono_now + 63'($urandom_range(0, 2000));
        else mono_now = mono_now + 63'({$urandom_range(0, 400), 20'd0});
        if ($urandom_range(0, 49) == 0) mono_now = rand_wide();
        case ($urandom_range(0, 9))
            0: wall_now = 63'd0;
            1: wall_now = wall_now + 63'($urandom_range(0, 400));
            2: wall_now = rand_wide();
            default: wall_now = wall_now + 63'($urandom_range(0, 40));
        endcase
        if (sel < 45)
            rq = make_request(stlb_pkg::KIND_LOGIN, h, $urandom_range(0, 2) != 0,
                              mono_now, wall_now);
        else if (sel < 80)
            rq = make_request(stlb_pkg::KIND_LOOKUP, h, 1'($urandom_range(0, 1)),
                              mono_now, wall_now);
        else if (sel < 97)
            rq = make_request(stlb_pkg::KIND_LOGOUT, h, 1'($urandom_range(0, 1)),
                              mono_now, wall_now);
        else
            rq = make_request(KIND_UNUSED, h, 1'($urandom_range(0, 1)), mono_now, wall_now);
        if ($urandom_range(0, 19) == 0) wall_now = 63'd500;
        send_request(rq);
    endtask

    // random burst traffic with gaps
    task automatic run_random(int count);
        int sent, burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [255:0] ones;
        ones = '1;
        for (int i = 0; i < 8; i++) token_pool[i] = rand_hash();
        token_pool[0] = '0;
        token_pool[1] = ones;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: disabled login, lookup and logout on empty table, unused kind
        send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b1, 63'd0, 63'd0));
        send_request(make_request(stlb_pkg::KIND_LOOKUP, '0, 1'b0, 63'd0, 63'd0));
        send_request(make_request(stlb_pkg::KIND_LOGOUT, ones, 1'b0, 63'd0, 63'd0));
        send_request(make_request(KIND_UNUSED, ones, 1'b1, '1, '1));
        drain_responses();
        write_register(stlb_pkg::CFG_LOGIN_ENABLED, 32'd1);
        write_register(stlb_pkg::CFG_LIFETIME, 32'd100);
        write_register(stlb_pkg::CFG_CAP, 32'd1);

        // failures past five, lockout, then success
        for (int k = 0; k < 7; k++) begin
            send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b0, mono_now, 63'd0));
            send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b0,
                                      mono_now + 63'd1234, 63'd0));
            mono_now = mono_now + 63'd2000000;
        end
        send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b1, mono_now, 63'd0));
        // fill table, unknown creation times, then evict
        for (int k = 0; k < 9; k++)
            send_request(make_request(stlb_pkg::KIND_LOGIN, token_pool[k % 8], 1'b1,
                                      mono_now, (k < 3) ? 63'd0 : 63'd1000 + 63'(k)));
        send_request(make_request(stlb_pkg::KIND_LOOKUP, token_pool[1], 1'b0, mono_now,
                                  63'd900));
        send_request(make_request(stlb_pkg::KIND_LOOKUP, token_pool[4], 1'b0, mono_now,
                                  63'd5000));
        send_request(make_request(stlb_pkg::KIND_LOOKUP, token_pool[5], 1'b0, mono_now,
                                  63'd10));
        send_request(make_request(stlb_pkg::KIND_LOGOUT, token_pool[1], 1'b0, mono_now,
                                  63'd0));
        // pause until every response is in
        drain_responses();

        // huge lockout with saturated retry, using zero cap as default
        write_register(stlb_pkg::CFG_CAP, 32'd0);
        write_register(stlb_pkg::CFG_LIFETIME, 32'd0);
        send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b0, '1 - 63'd5, 63'd0));
        drain_responses();
        write_register(stlb_pkg::CFG_CAP, 32'd65536);
        write_register(stlb_pkg::CFG_LIFETIME, 32'hFFFF_FFFF);
        mono_now = '0;
        send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b1, 63'd0, 63'd0));
        for (int k = 0; k < 20; k++) begin
            mono_now = mono_now + 63'd70000000000;
            send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b0, mono_now, 63'd0));
            send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b0,
                                      mono_now + 63'd1, 63'd0));
        end
        mono_now = mono_now + 63'd70000000000;
        send_request(make_request(stlb_pkg::KIND_LOGIN, ones, 1'b1, mono_now, 63'd7));
        drain_responses();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_register(stlb_pkg::CFG_LOGIN_ENABLED, (ph == 3) ? 32'd0 : 32'd1);
            case (ph % 4)
                0: write_register(stlb_pkg::CFG_LIFETIME, 32'd1);
                1: write_register(stlb_pkg::CFG_LIFETIME, $urandom_range(20, 500));
                2: write_register(stlb_pkg::CFG_LIFETIME, 32'hFFFF_FFFF);
                default: write_register(stlb_pkg::CFG_LIFETIME, 32'd0);
            endcase
            case (ph % 4)
                0: write_register(stlb_pkg::CFG_CAP, 32'd1);
                1: write_register(stlb_pkg::CFG_CAP, 32'd65536);
                2: write_register(stlb_pkg::CFG_CAP, $urandom_range(2, 400));
                default: write_register(stlb_pkg::CFG_CAP, 32'd0);
            endcase
            run_random(200);
            drain_responses();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
